// ----- rtl/core/bsp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Banked scratchpad package
// Shared constants, request codes, the staged request record and the address
// helper used by the core, the row store and the response slots.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int NUM_BANKS_DEF     = 4;
    localparam int ROWS_PER_BANK_DEF = 1024;
    localparam int LANES_DEF         = 8;

    localparam int BYTE_W     = 8;
    localparam int DATA_W     = 64;
    localparam int MASK_W     = 8;
    localparam int BANK_W     = 2;
    localparam int ROW_W      = 10;
    localparam int CMD_W      = 8;
    localparam int CNT_W      = 16;
    localparam int RESP_ADDR_W = 12;

    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_READ     = 2'd1,
        REQ_POP      = 2'd2,
        REQ_READ_POP = 2'd3
    } t_req_kind;

    // Request fields carried from the inputs through the stage register into the slot stage.
    typedef struct packed {
        t_req_kind          kind;
        logic [BANK_W-1:0]  bank;
        logic               bank_ok;
        logic [RESP_ADDR_W-1:0] addr;
        logic               last;
        logic [CMD_W-1:0]   cmd_id;
        logic [CNT_W-1:0]   byte_cnt;
        logic [CNT_W-1:0]   read_len;
        logic               dma_src;
    } t_item;

    // Global row address bank * rows + row. The row count is a power of two,
    // so the row is wrapped by a mask.
    function automatic logic [31:0] glob_addr(input logic [BANK_W-1:0] bank,
                                              input logic [ROW_W-1:0]  row,
                                              input int unsigned       rows);
        logic [31:0] row_m;
        row_m = 32'(row) & (rows - 32'd1);
        return 32'(bank) * rows + row_m;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/banked_scratchpad_memory_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Banked scratchpad memory core
// Byte-lane writes with DMA completions, reads into one held response slot
// per bank, and pops of the held responses.
// ----------------------------------------------------------------------------
// The result strobe o_valid is registered from r_s1_valid, the stage register.
// Throughput: one item per cycle while not busy; the row store takes its one
// read or write at the transfer edge and the slot stage finishes the item in
// the next cycle. Reset: after i_rst_n the row store is zeroed one row a cycle,
// holding busy high until all rows are cleared; all slots empty.
// The receiver cannot stall, and ROWS_PER_BANK must be a power of two.
module banked_scratchpad_memory_core #(
    parameter int NUM_BANKS     = bsp_pkg::NUM_BANKS_DEF,
    parameter int ROWS_PER_BANK = bsp_pkg::ROWS_PER_BANK_DEF,
    parameter int LANES         = bsp_pkg::LANES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       i_req_type,
    input  wire logic [bsp_pkg::BANK_W-1:0]       i_bank,
    input  wire logic [bsp_pkg::ROW_W-1:0]        i_row,
    input  wire logic [bsp_pkg::DATA_W-1:0]       i_write_data,
    input  wire logic [bsp_pkg::MASK_W-1:0]       i_write_mask,
    input  wire logic                             i_last,
    input  wire logic [bsp_pkg::CMD_W-1:0]        i_cmd_id,
    input  wire logic [bsp_pkg::CNT_W-1:0]        i_byte_cnt,
    input  wire logic [bsp_pkg::CNT_W-1:0]        i_read_len,
    input  wire logic                             i_dma_src,
    output logic                                  o_valid,
    output logic                                  o_accepted,
    output logic                                  o_completion_valid,
    output logic [bsp_pkg::CMD_W-1:0]             o_completion_cmd_id,
    output logic [bsp_pkg::CNT_W-1:0]             o_completion_bytes,
    output logic                                  o_resp_valid,
    output logic [bsp_pkg::RESP_ADDR_W-1:0]       o_resp_addr,
    output logic [bsp_pkg::DATA_W-1:0]            o_resp_data,
    output logic [bsp_pkg::MASK_W-1:0]            o_resp_mask,
    output logic [bsp_pkg::CNT_W-1:0]             o_resp_len,
    output logic [bsp_pkg::CMD_W-1:0]             o_resp_cmd_id,
    output logic                                  o_resp_dma_src
);

    logic                        w_xfer;
    logic                        w_clearing;
    logic [31:0]                 w_addr;
    logic                        w_bank_ok;
    bsp_pkg::t_item              w_item;
    logic                        r_s1_valid;
    bsp_pkg::t_item              r_s1_item;
    logic [bsp_pkg::DATA_W-1:0]  w_rd_data;

    assign busy      = w_clearing;
    assign w_xfer    = start & ~w_clearing;
    assign w_addr    = bsp_pkg::glob_addr(i_bank, i_row, ROWS_PER_BANK);
    assign w_bank_ok = (32'(i_bank) < NUM_BANKS);

    always_comb begin
        w_item.kind       = bsp_pkg::t_req_kind'(i_req_type);
        w_item.bank       = i_bank;
        w_item.bank_ok    = w_bank_ok;
        w_item.addr       = w_addr[bsp_pkg::RESP_ADDR_W-1:0];
        w_item.last       = i_last;
        w_item.cmd_id     = i_cmd_id;
        w_item.byte_cnt   = i_byte_cnt;
        w_item.read_len   = i_read_len;
        w_item.dma_src    = i_dma_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_s1_item <= w_item;
        end
    end

    bsp_row_store #(
        .NUM_BANKS     (NUM_BANKS),
        .ROWS_PER_BANK (ROWS_PER_BANK),
        .LANES         (LANES)
    ) u_row_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_xfer & w_bank_ok & (w_item.kind == bsp_pkg::REQ_WRITE)),
        .i_rd_en    (w_xfer & w_bank_ok),
        .i_addr     (w_addr),
        .i_wr_data  (i_write_data),
        .i_wr_mask  (i_write_mask),
        .o_rd_data  (w_rd_data),
        .o_clearing (w_clearing)
    );

    bsp_resp_slots #(
        .NUM_BANKS (NUM_BANKS),
        .LANES     (LANES)
    ) u_resp_slots (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (r_s1_valid),
        .i_item              (r_s1_item),
        .i_rd_data           (w_rd_data),
        .o_valid             (o_valid),
        .o_accepted          (o_accepted),
        .o_completion_valid  (o_completion_valid),
        .o_completion_cmd_id (o_completion_cmd_id),
        .o_completion_bytes  (o_completion_bytes),
        .o_resp_valid        (o_resp_valid),
        .o_resp_addr         (o_resp_addr),
        .o_resp_data         (o_resp_data),
        .o_resp_mask         (o_resp_mask),
        .o_resp_len          (o_resp_len),
        .o_resp_cmd_id       (o_resp_cmd_id),
        .o_resp_dma_src      (o_resp_dma_src)
    );

endmodule
`default_nettype wire

// ----- rtl/core/bsp_row_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scratchpad row store
// One memory holding all banks, with byte-lane writes, a registered read port
// and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module bsp_row_store #(
    parameter int NUM_BANKS     = bsp_pkg::NUM_BANKS_DEF,
    parameter int ROWS_PER_BANK = bsp_pkg::ROWS_PER_BANK_DEF,
    parameter int LANES         = bsp_pkg::LANES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire logic                        i_rd_en,
    input  wire logic [31:0]                 i_addr,
    input  wire logic [bsp_pkg::DATA_W-1:0]  i_wr_data,
    input  wire logic [bsp_pkg::MASK_W-1:0]  i_wr_mask,
    output logic      [bsp_pkg::DATA_W-1:0]  o_rd_data,
    output logic                             o_clearing
);

    localparam int DEPTH  = NUM_BANKS * ROWS_PER_BANK;
    localparam int MEM_AW = $clog2(DEPTH);
    localparam int WORD_W = bsp_pkg::BYTE_W * LANES;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd_word;
    logic [MEM_AW-1:0] r_clr_addr;
    logic              r_clr_active;
    logic [MEM_AW-1:0] w_addr;

    assign w_addr     = i_addr[MEM_AW-1:0];
    assign o_clearing = r_clr_active;
    assign o_rd_data  = bsp_pkg::DATA_W'(r_rd_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + MEM_AW'(1);
            if (r_clr_addr == MEM_AW'(DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            for (int l = 0; l < LANES; l++) begin
                if (i_wr_mask[l]) begin
                    mem[w_addr][l*bsp_pkg::BYTE_W +: bsp_pkg::BYTE_W] <=
                        i_wr_data[l*bsp_pkg::BYTE_W +: bsp_pkg::BYTE_W];
                end
            end
        end
        if (i_rd_en) begin
            r_rd_word <= mem[w_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bsp_resp_slots.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scratchpad response slots
// One held read response per bank, the pop and refuse rules, and the result
// register that drives the outputs.
// ----------------------------------------------------------------------------
module bsp_resp_slots #(
    parameter int NUM_BANKS = bsp_pkg::NUM_BANKS_DEF,
    parameter int LANES     = bsp_pkg::LANES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire bsp_pkg::t_item                  i_item,
    input  wire logic [bsp_pkg::DATA_W-1:0]      i_rd_data,
    output logic                                 o_valid,
    output logic                                 o_accepted,
    output logic                                 o_completion_valid,
    output logic [bsp_pkg::CMD_W-1:0]            o_completion_cmd_id,
    output logic [bsp_pkg::CNT_W-1:0]            o_completion_bytes,
    output logic                                 o_resp_valid,
    output logic [bsp_pkg::RESP_ADDR_W-1:0]      o_resp_addr,
    output logic [bsp_pkg::DATA_W-1:0]           o_resp_data,
    output logic [bsp_pkg::MASK_W-1:0]           o_resp_mask,
    output logic [bsp_pkg::CNT_W-1:0]            o_resp_len,
    output logic [bsp_pkg::CMD_W-1:0]            o_resp_cmd_id,
    output logic                                 o_resp_dma_src
);

    localparam int BANK_IW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam logic [bsp_pkg::MASK_W-1:0] LANE_MASK = bsp_pkg::MASK_W'((1 << LANES) - 1);

    logic                              r_held_valid [NUM_BANKS];
    logic [bsp_pkg::DATA_W-1:0]        r_held_data  [NUM_BANKS];
    logic [bsp_pkg::RESP_ADDR_W-1:0]   r_held_addr  [NUM_BANKS];
    logic [bsp_pkg::CNT_W-1:0]         r_held_len   [NUM_BANKS];
    logic [bsp_pkg::CMD_W-1:0]         r_held_cmd   [NUM_BANKS];
    logic                              r_held_dma   [NUM_BANKS];

    logic [BANK_IW-1:0] w_bidx;
    logic               w_held;
    logic               w_is_pop;
    logic               w_is_read;
    logic               w_pop;
    logic               w_latch;
    logic               n_accepted;
    logic               n_cpl;

    assign w_bidx = BANK_IW'(i_item.bank);
    assign w_held = r_held_valid[w_bidx];

    always_comb begin
        w_is_pop  = 1'b0;
        w_is_read = 1'b0;
        unique case (i_item.kind)
            bsp_pkg::REQ_WRITE:    ;
            bsp_pkg::REQ_READ:     w_is_read = 1'b1;
            bsp_pkg::REQ_POP:      w_is_pop  = 1'b1;
            bsp_pkg::REQ_READ_POP: begin
                w_is_read = 1'b1;
                w_is_pop  = 1'b1;
            end
            default: ;
        endcase
    end

    // A read goes into the slot when it is empty or popped by the same item.
    assign w_pop   = i_item.bank_ok & w_is_pop & w_held;
    assign w_latch = i_item.bank_ok & w_is_read & (~w_held | w_pop);
    assign n_cpl   = i_item.bank_ok & (i_item.kind == bsp_pkg::REQ_WRITE) & i_item.last;
    assign n_accepted = i_item.bank_ok &
                        ((i_item.kind == bsp_pkg::REQ_WRITE) | w_latch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_held_valid[b] <= 1'b0;
            end
        end else if (i_valid) begin
            if (w_latch) begin
                r_held_valid[w_bidx] <= 1'b1;
            end else if (w_pop) begin
                r_held_valid[w_bidx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_latch) begin
            r_held_data[w_bidx] <= i_rd_data;
            r_held_addr[w_bidx] <= i_item.addr;
            r_held_len[w_bidx]  <= i_item.read_len;
            r_held_cmd[w_bidx]  <= i_item.cmd_id;
            r_held_dma[w_bidx]  <= i_item.dma_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // Fields of a result that carries no completion or response read as zero.
    always_ff @(posedge i_clk) begin
        o_accepted          <= n_accepted;
        o_completion_valid  <= n_cpl;
        o_completion_cmd_id <= n_cpl ? i_item.cmd_id : '0;
        o_completion_bytes  <= n_cpl ? i_item.byte_cnt : '0;
        o_resp_valid        <= w_pop;
        o_resp_addr         <= w_pop ? r_held_addr[w_bidx] : '0;
        o_resp_data         <= w_pop ? r_held_data[w_bidx] : '0;
        o_resp_mask         <= w_pop ? LANE_MASK : '0;
        o_resp_len          <= w_pop ? r_held_len[w_bidx] : '0;
        o_resp_cmd_id       <= w_pop ? r_held_cmd[w_bidx] : '0;
        o_resp_dma_src      <= w_pop ? r_held_dma[w_bidx] : 1'b0;
    end

endmodule
`default_nettype wire
